>>> sv/bracket_and_operator_validator_unit_defines.svh
// assertion macros for the bracket and operator validator
`ifndef BRACKET_AND_OPERATOR_VALIDATOR_UNIT_DEFINES_SVH
`define BRACKET_AND_OPERATOR_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BOVU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BOVU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bovu_pkg.sv
// shared types, constants and character decode for the bracket and operator validator
`timescale 1ns / 1ps

package bovu_pkg;

   localparam int BOVU_STACK_DEPTH = 64;

   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_PAREN  = 2'd1;
   localparam logic [1:0] KIND_BRACE  = 2'd2;
   localparam logic [1:0] KIND_SQUARE = 2'd3;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_MISMATCH = 3'd1,
      ERR_EMPTY    = 3'd2,
      ERR_UNCLOSED = 3'd3,
      ERR_ADJACENT = 3'd4,
      ERR_OVERFLOW = 3'd5
   } err_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic       valid_res;
      logic [2:0] error_code;
   } rsp_payload_type;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic       pop;
      logic [1:0] kind;
   } stack_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       one;
      logic       full;
      logic [1:0] top;
   } stack_status_type;

   function automatic logic [1:0] opener_kind(input logic [7:0] c);
      logic [1:0] k;
      case (c)
         CH_LPAREN:  k = KIND_PAREN;
         CH_LBRACE:  k = KIND_BRACE;
         CH_LSQUARE: k = KIND_SQUARE;
         default:    k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [1:0] closer_kind(input logic [7:0] c);
      logic [1:0] k;
      case (c)
         CH_RPAREN:  k = KIND_PAREN;
         CH_RBRACE:  k = KIND_BRACE;
         CH_RSQUARE: k = KIND_SQUARE;
         default:    k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_PERCENT};
   endfunction

endpackage

>>> sv/bracket_and_operator_validator_unit.sv
// Checks bracket balance ((), {}, []) and adjacent operators (+ - * / ^ %) in an
// expression sent one character per transaction, and gives one result after the
// character marked last: valid_res and the code of the first error. One character
// is taken every cycle with no stall of its own; the pace is set by the stack,
// whose top sits in a register and whose lower entries sit in a registered ram
// that is read one step ahead, so a push or pop completes each cycle. The result
// appears on rsp in the cycle after the last character is taken and is held in an
// output register; req is stalled only while that register holds a result and
// rsp_ready is low. Nesting deeper than STACK_DEPTH reports overflow. Reset
// clears the control state at once; the ram needs no clearing pass.
`timescale 1ns / 1ps

module bracket_and_operator_validator_unit import bovu_pkg::*; #(
   parameter int STACK_DEPTH = BOVU_STACK_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   stack_cmd_type    stack_cmd;
   stack_status_type stack_status;
   logic             step;
   logic             rsp_load;
   rsp_payload_type  rsp_next;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   bovu_check u_check (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req      (req_data),
      .status   (stack_status),
      .cmd      (stack_cmd),
      .rsp_load (rsp_load),
      .rsp      (rsp_next)
   );

   bovu_stack #(
      .StackDepth (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stack_cmd),
      .status (stack_status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/bovu_stack.sv
// bracket kind stack: top in a register, the entries below it in a registered ram
`timescale 1ns / 1ps

module bovu_stack import bovu_pkg::*; #(
   parameter int StackDepth = BOVU_STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  stack_cmd_type    cmd,
   output stack_status_type status
);

   localparam int AddrWidth  = $clog2(StackDepth);
   localparam int LevelWidth = $clog2(StackDepth + 1);

   logic [1:0]            mem [StackDepth];
   logic [LevelWidth-1:0] level_ff, level_in;
   logic [1:0]            top_ff, top_in;
   logic [1:0]            rd_data_ff;
   logic [1:0]            fwd_data_ff, fwd_data_in;
   logic                  fwd_sel_ff, fwd_sel_in;
   logic                  wr_en;
   logic [LevelWidth-1:0] wr_level, rd_level;
   logic [AddrWidth-1:0]  wr_addr, rd_addr;
   logic [1:0]            below;

   // entry under the top; a push writes the same address the next read wants
   assign below = fwd_sel_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      level_in    = level_ff;
      top_in      = top_ff;
      wr_en       = 1'b0;
      fwd_sel_in  = 1'b0;
      fwd_data_in = top_ff;
      if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.push) begin
         level_in   = level_ff + LevelWidth'(1);
         top_in     = cmd.kind;
         wr_en      = (level_ff != '0);
         fwd_sel_in = 1'b1;
      end else if (cmd.pop) begin
         level_in = level_ff - LevelWidth'(1);
         top_in   = below;
      end
   end

   assign wr_level = level_ff - LevelWidth'(1);
   assign wr_addr  = wr_level[AddrWidth-1:0];
   assign rd_level = level_in - LevelWidth'(2);
   assign rd_addr  = rd_level[AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         fwd_sel_ff <= 1'b0;
      end else begin
         level_ff   <= level_in;
         fwd_sel_ff <= fwd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign status.empty = (level_ff == '0);
   assign status.one   = (level_ff == LevelWidth'(1));
   assign status.full  = (level_ff == LevelWidth'(StackDepth));
   assign status.top   = top_ff;

endmodule

>>> sv/bovu_check.sv
// per-character checking, first-error latch and result formation
`timescale 1ns / 1ps

module bovu_check import bovu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  req_payload_type  req,
   input  stack_status_type status,
   output stack_cmd_type    cmd,
   output logic             rsp_load,
   output rsp_payload_type  rsp
);

   err_type err_ff, err_in;
   logic    prev_op_ff, prev_op_in;

   always_comb begin
      logic [1:0] ok;
      logic [1:0] ck;
      logic       op;
      logic       open_after;
      err_type    final_err;
      ok         = opener_kind(req.ch);
      ck         = closer_kind(req.ch);
      op         = is_operator(req.ch);
      open_after = 1'b0;
      final_err  = ERR_NONE;
      cmd        = '0;
      err_in     = err_ff;
      prev_op_in = prev_op_ff;
      rsp_load   = 1'b0;
      if (step) begin
         // once an error is latched the stack is frozen until the last character clears it
         if (err_ff == ERR_NONE) begin
            if (ok != KIND_NONE) begin
               if (status.full) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  cmd.push = 1'b1;
                  cmd.kind = ok;
               end
            end else if (ck != KIND_NONE) begin
               if (status.empty) begin
                  err_in = ERR_EMPTY;
               end else if (status.top != ck) begin
                  err_in = ERR_MISMATCH;
               end else begin
                  cmd.pop = 1'b1;
               end
            end else if (op && prev_op_ff) begin
               err_in = ERR_ADJACENT;
            end
         end
         prev_op_in = op;
         if (req.last) begin
            open_after = cmd.push || (cmd.pop ? !status.one : !status.empty);
            final_err  = err_in;
            if (err_in == ERR_NONE && open_after) begin
               final_err = ERR_UNCLOSED;
            end
            rsp_load   = 1'b1;
            cmd.clear  = 1'b1;
            err_in     = ERR_NONE;
            prev_op_in = 1'b0;
         end
      end
      rsp.valid_res  = (final_err == ERR_NONE);
      rsp.error_code = final_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff     <= ERR_NONE;
         prev_op_ff <= 1'b0;
      end else begin
         err_ff     <= err_in;
         prev_op_ff <= prev_op_in;
      end
   end

endmodule

>>> sv/bovu_checker.sv
// port-level checks for the validator, bound to the top level
`timescale 1ns / 1ps
`include "bracket_and_operator_validator_unit_defines.svh"

module bovu_checker import bovu_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   `BOVU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp transaction dropped or changed while stalled")
   `BOVU_ASSERT_NOW(a_flag_matches_code, rsp_valid, rsp_data.valid_res == (rsp_data.error_code == ERR_NONE), "valid_res disagrees with error_code")
   `BOVU_ASSERT_NOW(a_code_range, rsp_valid, rsp_data.error_code <= ERR_OVERFLOW, "error_code out of range")
   `BOVU_ASSERT_NOW(a_rsp_after_last, $rose(rsp_valid), $past(req_valid && req_ready && req_data.last), "result without a last character")
   `BOVU_ASSERT_NOW(a_ready_when_free, !rsp_valid, req_ready, "req stalled with empty output register")

endmodule

bind bracket_and_operator_validator_unit bovu_checker u_bovu_checker (.*);
